// ----- src/si2d_pkg.sv -----
package si2d_pkg;
    localparam int MANT_W = 64;
    localparam int EXP_W  = 16;
    localparam int LZ_W   = 7;
    localparam int BE_W   = 18;
    localparam int BIAS_TOP = 1086;
    localparam logic [63:0] SIGN_BIT = 64'h8000000000000000;
    localparam logic [63:0] INF_BITS = 64'h7ff0000000000000;

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [63:0] n;
        logic signed [BE_W-1:0] biased;
    } t_norm;
endpackage

// ----- src/si2d_norm.sv -----
module si2d_norm
    import si2d_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic                    i_neg,
    input  logic signed [EXP_W-1:0] i_exp,
    input  logic [MANT_W-1:0]       i_mant,
    output logic                    o_vld,
    output t_norm                   o_norm
);
    // stage a: leading-zero count, stage b: shift and bias
    logic [LZ_W-1:0] n_lz;
    logic [LZ_W-1:0] r_lz;
    logic [MANT_W-1:0] r_mant;
    logic signed [EXP_W-1:0] r_exp;
    logic r_neg, r_va, r_vb;
    t_norm r_norm;

    always_comb begin
        n_lz = LZ_W'(64);
        for (int i = 0; i < 64; i++) begin
            if (i_mant[i]) n_lz = LZ_W'(63 - i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_vld;
            r_vb <= r_va;
        end
        r_lz   <= n_lz;
        r_mant <= i_mant;
        r_exp  <= i_exp;
        r_neg  <= i_neg;
        r_norm.neg    <= r_neg;
        r_norm.zero   <= (r_mant == '0);
        r_norm.n      <= r_mant << r_lz[5:0];
        r_norm.biased <= BE_W'(r_exp) - BE_W'(signed'({1'b0, r_lz}))
                         + BE_W'(BIAS_TOP);
    end

    assign o_vld  = r_vb;
    assign o_norm = r_norm;
endmodule

// ----- src/si2d_round.sv -----
module si2d_round
    import si2d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_norm       i_norm,
    output logic        o_vld,
    output logic [63:0] o_bits
);
    // stage c: align to subnormal grid, stage d: round and pack
    logic signed [BE_W-1:0] shamt;
    logic [63:0] n_q, n_r, n_half;
    logic n_sub, n_flush;
    logic [63:0] r_q, r_r, r_half;
    logic r_sub, r_flush, r_zero, r_neg, r_vc, r_vd;
    logic signed [BE_W-1:0] r_be;
    logic [63:0] r_bits;
    logic        up;
    logic [53:0] qn;
    logic [63:0] qs;
    logic [11:0] be2;
    logic [63:0] n_bits;

    always_comb begin
        // s = -f - 1074 = 12 - biased
        shamt  = BE_W'(12) - i_norm.biased;
        n_sub  = (i_norm.biased < 1);
        n_flush = 1'b0;
        n_q = i_norm.n >> 11;
        n_r = {53'd0, i_norm.n[10:0]};
        n_half = 64'h400;
        if (n_sub) begin
            if (shamt > 64) begin
                n_flush = 1'b1;
                n_q = '0; n_r = '0; n_half = '0;
            end else if (shamt == 64) begin
                n_q = '0; n_r = i_norm.n; n_half = SIGN_BIT;
            end else begin
                n_q = i_norm.n >> shamt[5:0];
                n_half = 64'd1 << (shamt[5:0] - 6'd1);
                n_r = i_norm.n & ((64'd1 << shamt[5:0]) - 64'd1);
            end
        end
    end

    always_comb begin
        up = (r_r > r_half) || ((r_r == r_half) && r_q[0]);
        qn = {1'b0, r_q[52:0]} + {53'd0, up};
        be2 = r_be[11:0];
        qs = r_q + {63'd0, up};
        if (r_zero || r_flush) begin
            n_bits = {r_neg, 63'd0};
        end else if (r_sub) begin
            n_bits = {r_neg, qs[62:0]};
        end else if (qn[53]) begin
            // carry out of the significand bumps the exponent
            if (r_be >= 2046) n_bits = {r_neg, INF_BITS[62:0]};
            else n_bits = {r_neg, 11'(be2 + 12'd1), 52'd0};
        end else if (r_be >= 2047) begin
            n_bits = {r_neg, INF_BITS[62:0]};
        end else begin
            n_bits = {r_neg, be2[10:0], qn[51:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_vc <= i_vld;
            r_vd <= r_vc;
        end
        r_q <= n_q; r_r <= n_r; r_half <= n_half;
        r_sub <= n_sub; r_flush <= n_flush;
        r_zero <= i_norm.zero; r_neg <= i_norm.neg; r_be <= i_norm.biased;
        r_bits <= n_bits;
    end

    assign o_vld  = r_vd;
    assign o_bits = r_bits;
endmodule

// ----- src/scaled_integer_to_binary64_top.sv -----
// o_done strobes when an accepted request leaves the round stage
// throughput: one request per cycle, busy is always low
// the four stages are count, shift, align, round; the receiver cannot stall
// reset (synchronous, active low) clears only the valid bits
module scaled_integer_to_binary64_top
    import si2d_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_sign_negative,
    input  logic signed [EXP_W-1:0] i_exponent,
    input  logic [MANT_W-1:0]       i_mantissa,
    output logic                    o_done,
    output logic [63:0]             o_result_bits
);
    // no state between requests, so the pipe never pushes back
    logic  acc, v_norm;
    t_norm norm;

    assign busy = 1'b0;
    assign acc  = start && !busy;

    // normalize: leading-zero count then shift with exponent bias
    si2d_norm u_norm (
        .i_clk, .i_rst_n, .i_vld(acc), .i_neg(i_sign_negative),
        .i_exp(i_exponent), .i_mant(i_mantissa), .o_vld(v_norm), .o_norm(norm)
    );

    // round to nearest even, subnormal grid, overflow to infinity
    si2d_round u_round (
        .i_clk, .i_rst_n, .i_vld(v_norm), .i_norm(norm),
        .o_vld(o_done), .o_bits(o_result_bits)
    );

`ifndef SYNTHESIS
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##4 o_done) else $error("lost request");
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(acc, 4) && $past(i_rst_n, 4) |-> !o_done) else $error("extra result");
`endif
endmodule

// ----- tb/sv/tb_scaled_integer_to_binary64_top.sv -----
`timescale 1ns / 100ps

module tb_scaled_integer_to_binary64_top
    import si2d_pkg::*;
;
    class binary64_scoreboard;
        logic [63:0] pending_bits[$];
        int          mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // scaled integer to binary64, round to nearest even
        function logic [63:0] encode_binary64(logic neg, logic signed [15:0] e,
                                              logic [63:0] m);
            logic [63:0] sgn;
            logic [63:0] n;
            logic [63:0] q;
            logic [63:0] r;
            logic [63:0] half;
            int          lz;
            int          f;
            int          bexp;
            int          sh;
            sgn = neg ? SIGN_BIT : 64'd0;
            if (m == 64'd0) return sgn;
            lz = 0;
            n = m;
            while (!n[63]) begin
                n = n << 1;
                lz++;
            end
            f = int'(e) - lz;
            bexp = f + 1086;
            if (bexp >= 1) begin
                q = n >> 11;
                r = n & 64'h7ff;
                if (r > 64'h400 || (r == 64'h400 && q[0])) q = q + 1;
                if (q == 64'h0020000000000000) begin
                    q = q >> 1;
                    bexp++;
                end
                if (bexp >= 2047) return sgn | INF_BITS;
                return sgn | (64'(bexp) << 52) | (q & 64'h000fffffffffffff);
            end
            sh = -f - 1074;
            if (sh > 64) return sgn;
            if (sh == 64) begin
                q = 64'd0;
                r = n;
                half = SIGN_BIT;
            end else begin
                q = n >> sh;
                r = n & ((64'd1 << sh) - 64'd1);
                half = 64'd1 << (sh - 1);
            end
            if (r > half || (r == half && q[0])) q = q + 1;
            return sgn | q;
        endfunction

        function void note_request(logic neg, logic signed [15:0] e, logic [63:0] m);
            pending_bits.push_back(encode_binary64(neg, e, m));
        endfunction

        function void report_mismatch(string what);
            $display("mismatch: %s", what);
            mismatch_count++;
        endfunction

        function void check_result(logic [63:0] got);
            logic [63:0] want;
            if (pending_bits.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = pending_bits.pop_front();
            if (got !== want)
                report_mismatch($sformatf("result_bits got %h want %h", got, want));
        endfunction
    endclass

    // clock, reset and block ports
    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_sign_negative;
    logic signed [15:0] i_exponent;
    logic [63:0]        i_mantissa;
    logic               o_done;
    logic [63:0]        o_result_bits;

    binary64_scoreboard conv_board;
    int                 cycle_count = 0;
    int                 issued;

    localparam int CYCLE_LIMIT = 200000;

    scaled_integer_to_binary64_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_sign_negative (i_sign_negative),
        .i_exponent      (i_exponent),
        .i_mantissa      (i_mantissa),
        .o_done          (o_done),
        .o_result_bits   (o_result_bits)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // results are taken on the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) conv_board.check_result(o_result_bits);
    end

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // present one request and hold it until the block takes it;
    // start is left high so back-to-back requests need no toggle
    task automatic send_request(logic neg, logic signed [15:0] e, logic [63:0] m);
        start           <= 1'b1;
        i_sign_negative <= neg;
        i_exponent      <= e;
        i_mantissa      <= m;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        conv_board.note_request(neg, e, m);
        issued++;
    endtask

    // drop start for a burst of idle cycles
    task automatic idle_burst(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // wait until every outstanding request has produced its result
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (conv_board.pending_bits.size() != 0) @(posedge i_clk);
    endtask

    // random 64-bit mantissa with a random leading-zero count,
    // plus some patterns sitting exactly on a rounding tie
    function automatic logic [63:0] rand_mantissa();
        logic [63:0] m;
        int          shift;
        m = {$urandom, $urandom};
        shift = $urandom_range(0, 63);
        m = m >> shift;
        case ($urandom_range(0, 5))
            0: m = m & ~64'h7ff | 64'h400;     // tie at the 53-bit grid
            1: m = m | 64'h7ff;                // rounds up, may carry out
            2: m = 64'd0;
            default: ;
        endcase
        return m;
    endfunction

    // exponents mostly near the normal and subnormal edges
    function automatic logic signed [15:0] rand_exponent();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'(960 + $urandom_range(0, 40));    // overflow edge
            2: return 16'(-1140 + $urandom_range(0, 80));  // subnormal band
            3: return 16'(-1200 + $urandom_range(0, 70));  // underflow to zero
            default: return 16'($urandom_range(0, 200)) - 16'sd100;
        endcase
    endfunction

    initial begin
        int                 k;
        logic signed [15:0] e;
        conv_board      = new();
        issued          = 0;
        start           = 1'b0;
        i_sign_negative = 1'b0;
        i_exponent      = '0;
        i_mantissa      = '0;
        i_rst_n         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zeros of both signs, field extremes
        send_request(1'b0, 16'sh7fff, 64'd0);
        send_request(1'b1, -16'sd32768, 64'd0);
        send_request(1'b0, 16'sd0, 64'd1);
        send_request(1'b1, 16'sd0, 64'hffffffffffffffff);
        send_request(1'b0, 16'sh7fff, 64'hffffffffffffffff);
        send_request(1'b1, -16'sd32768, 64'hffffffffffffffff);
        // largest finite, and rounding carry into infinity
        send_request(1'b0, 16'sd960, 64'hfffffffffffff800);
        send_request(1'b1, 16'sd960, 64'hfffffffffffffc00);
        send_request(1'b0, 16'sd971, 64'd1 << 52);
        // ties to even at 53 bits, both parities
        send_request(1'b0, 16'sd0, 64'h8000000000000400);
        send_request(1'b0, 16'sd0, 64'h8000000000000c00);
        send_request(1'b1, 16'sd0, 64'h8000000000000401);
        // smallest subnormal, half of it, just above half
        send_request(1'b0, -16'sd1074, 64'd1);
        send_request(1'b1, -16'sd1075, 64'd1);
        send_request(1'b0, -16'sd1076, 64'd3);
        send_request(1'b0, -16'sd1075, 64'd3);
        // normal rounding up near the bottom of the range, and the smallest normal
        send_request(1'b0, -16'sd1075, 64'h003fffffffffffff);
        send_request(1'b0, -16'sd1022, 64'd1);
        // shift of exactly 64 and beyond into the zero region
        send_request(1'b0, -16'sd1138, 64'h8000000000000001);
        send_request(1'b1, -16'sd1138, 64'h8000000000000000);
        send_request(1'b0, -16'sd1200, 64'hffffffffffffffff);
        drain();

        // random part with bursts of idle on the sender side
        for (k = 0; k < 520; k++) begin
            if (k < 450 && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 8));
            if (k == 250) drain();  // hold off until everything is back
            e = rand_exponent();
            send_request(1'(($urandom)), e, rand_mantissa());
        end
        drain();
        repeat (10) @(posedge i_clk);

        if (conv_board.mismatch_count == 0 && conv_board.pending_bits.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
